[rtl/cau_pkg.sv]
// Shared constants, types and functions of the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int NSTEPS       = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int RED_STEPS    = 60 - FRAC_BITS;
    localparam int DIV_STEPS    = 33;
    localparam int SQRT_STEPS   = 32;
    localparam int SEC1_PART    = (RED_STEPS > NSTEPS) ? RED_STEPS : NSTEPS;
    localparam int SEC1_LEN     = (SEC1_PART > DIV_STEPS) ? SEC1_PART : DIV_STEPS;
    localparam int SEC2_LEN     = (NSTEPS > SQRT_STEPS) ? NSTEPS : SQRT_STEPS;

    localparam logic [63:0] PI_Q60        = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_PI_Q60   = PI_Q60 >> 1;
    localparam logic [63:0] THREE_HALF_PI = 64'd3 * HALF_PI_Q60;
    localparam logic [63:0] TWO_PI_Q60    = PI_Q60 << 1;
    localparam logic [63:0] INV_GAIN_Q32  = 64'd2608131496;

    localparam int QDEPTH = 4;
    localparam int QPTR   = $clog2(QDEPTH);
    localparam int QCNT   = $clog2(QDEPTH + 1);

    localparam logic [3:0] ACT_ADD  = 4'd0;
    localparam logic [3:0] ACT_SUB  = 4'd1;
    localparam logic [3:0] ACT_MUL  = 4'd2;
    localparam logic [3:0] ACT_DIV  = 4'd3;
    localparam logic [3:0] ACT_CONJ = 4'd4;
    localparam logic [3:0] ACT_POL  = 4'd5;
    localparam logic [3:0] ACT_SQRT = 4'd6;
    localparam logic [3:0] ACT_FPOL = 4'd7;
    localparam logic [3:0] ACT_CMP  = 4'd8;

    typedef struct packed {
        logic [3:0]         act;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic               eq;
        logic               bz;
        logic               arz;
        logic               aiz;
    } item_t;

    // Arctangent of 2^-i with 60 fraction bits, from a truncated series.
    function automatic logic [63:0] atan_q60(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int k;
        acc = 64'd0;
        if (i == 0)
        begin
            acc = PI_Q60 >> 2;
        end
        else
        begin
            for (k = 0; i * (2 * k + 1) <= 60; k++)
            begin
                term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if ((k & 1) != 0)
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
        end
        return acc;
    endfunction

endpackage

[rtl/cau_front.sv]
// Front end: accepts operations from the input stream and classifies the operands.
module cau_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [127:0]   s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [3:0]     s_tuser,   // action
    output logic           q_valid,
    input  logic           q_ready,
    output cau_pkg::item_t q_item
);

    logic           valid_reg;
    cau_pkg::item_t item_reg;
    cau_pkg::item_t item_next;

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_comb
    begin
        item_next.act = s_tuser;
        item_next.ar  = s_tdata[31:0];
        item_next.ai  = s_tdata[63:32];
        item_next.br  = s_tdata[95:64];
        item_next.bi  = s_tdata[127:96];
        item_next.eq  = (s_tdata[31:0] == s_tdata[95:64]) && (s_tdata[63:32] == s_tdata[127:96]);
        item_next.bz  = (s_tdata[95:64] == 32'd0) && (s_tdata[127:96] == 32'd0);
        item_next.arz = (s_tdata[31:0] == 32'd0);
        item_next.aiz = (s_tdata[63:32] == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[rtl/cau_queue.sv]
// Short queue that decouples the front end from the execution pipeline.
module cau_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cau_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output cau_pkg::item_t out_item
);

    cau_pkg::item_t                mem [cau_pkg::QDEPTH];
    logic [cau_pkg::QPTR-1:0]      wr_ptr_reg;
    logic [cau_pkg::QPTR-1:0]      rd_ptr_reg;
    logic [cau_pkg::QCNT-1:0]      count_reg;
    logic                          push;
    logic                          pop;

    assign in_ready  = (count_reg != cau_pkg::QCNT'(cau_pkg::QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/cau_back.sv]
// Execution pipeline: products, dividers, square roots, CORDIC and result selection.
module cau_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cau_pkg::item_t in_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,   // res_re, res_im
    output logic [2:0]     m_tuser    // equal, div_by_zero, saturated
);

    localparam int F      = cau_pkg::FRAC_BITS;
    localparam int S_P    = 0;
    localparam int S_S    = 1;
    localparam int S_I    = 2;
    localparam int S_A0   = 3;
    localparam int S_M1   = S_A0 + cau_pkg::SEC1_LEN;
    localparam int S_M2   = S_M1 + 1;
    localparam int S_B0   = S_M2 + 1;
    localparam int S_M3   = S_B0 + cau_pkg::SEC2_LEN;
    localparam int S_MUL  = S_M3 + 1;
    localparam int NST    = S_MUL + 1;

    localparam logic [63:0] RND_F   = 64'd1 << (F - 1);
    localparam logic [63:0] RND_ANG = 64'd1 << (59 - F);
    localparam logic [63:0] TPF     = (cau_pkg::TWO_PI_Q60 + RND_ANG) >> (60 - F);

    typedef struct packed {
        logic [3:0]         act;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic               eq;
        logic               bz;
        logic               arz;
        logic               aiz;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_ii;
        logic signed [63:0] p_ri;
        logic signed [63:0] p_ir;
        logic signed [63:0] sq_ar;
        logic signed [63:0] sq_ai;
        logic signed [63:0] sq_br;
        logic signed [63:0] sq_bi;
        logic               mre_neg;
        logic               mim_neg;
        logic               dre_neg;
        logic               dim_neg;
        logic [63:0]        mre_mag;
        logic [63:0]        mim_mag;
        logic [63:0]        dre_num;
        logic [63:0]        dim_num;
        logic [63:0]        den;
        logic [63:0]        msq;
        logic [63:0]        dre_rem;
        logic [63:0]        dim_rem;
        logic [32:0]        dre_q;
        logic [32:0]        dim_q;
        logic               dre_ovf;
        logic               dim_ovf;
        logic [63:0]        s1_v;
        logic [63:0]        s1_r;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] vz;
        logic               vbase;
        logic [63:0]        red;
        logic               red_neg;
        logic [63:0]        ang;
        logic [63:0]        mag1;
        logic signed [31:0] mul_re;
        logic signed [31:0] mul_im;
        logic signed [31:0] div_re;
        logic signed [31:0] div_im;
        logic               mul_sat;
        logic               div_sat;
        logic               mag_sat;
        logic [31:0]        af;
        logic signed [63:0] rx;
        logic signed [63:0] ry;
        logic signed [63:0] rz;
        logic               rflip;
        logic [63:0]        s2_v;
        logic [63:0]        s2_r;
        logic signed [33:0] cs_c;
        logic signed [33:0] cs_s;
        logic signed [31:0] rad;
        logic signed [65:0] pc;
        logic signed [65:0] ps;
    } pipe_t;

    // Sign and magnitude to a saturated 32-bit value; the top bit flags clipping.
    function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] mag);
        logic [63:0] negm;
        logic [32:0] r;
        negm = 64'd0 - mag;
        if (neg)
        begin
            if (mag > 64'h80000000)
            begin
                r = {1'b1, 32'h80000000};
            end
            else
            begin
                r = {1'b0, negm[31:0]};
            end
        end
        else if (mag > 64'h7FFFFFFF)
        begin
            r = {1'b1, 32'h7FFFFFFF};
        end
        else
        begin
            r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

    function automatic logic [32:0] clamp33(input logic [32:0] v);
        logic [32:0] r;
        if (v[32] && !v[31])
        begin
            r = {1'b1, 32'h80000000};
        end
        else if (!v[32] && v[31])
        begin
            r = {1'b1, 32'h7FFFFFFF};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    pipe_t             st_reg  [NST];
    pipe_t             st_next [NST];
    logic [NST-1:0]    vld_reg;
    logic              en;
    logic              out_valid_reg;
    logic [63:0]       out_data_reg;
    logic [2:0]        out_user_reg;
    logic [63:0]       fin_data;
    logic [2:0]        fin_user;

    assign en       = !out_valid_reg || m_tready;
    assign in_ready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_st
            pipe_t nx;
            if (g == S_P)
            begin : g_prod
                always_comb
                begin
                    nx       = '0;
                    nx.act   = in_item.act;
                    nx.ar    = in_item.ar;
                    nx.ai    = in_item.ai;
                    nx.br    = in_item.br;
                    nx.bi    = in_item.bi;
                    nx.eq    = in_item.eq;
                    nx.bz    = in_item.bz;
                    nx.arz   = in_item.arz;
                    nx.aiz   = in_item.aiz;
                    nx.p_rr  = in_item.ar * in_item.br;
                    nx.p_ii  = in_item.ai * in_item.bi;
                    nx.p_ri  = in_item.ar * in_item.bi;
                    nx.p_ir  = in_item.ai * in_item.br;
                    nx.sq_ar = in_item.ar * in_item.ar;
                    nx.sq_ai = in_item.ai * in_item.ai;
                    nx.sq_br = in_item.br * in_item.br;
                    nx.sq_bi = in_item.bi * in_item.bi;
                end
            end
            else if (g == S_S)
            begin : g_sum
                logic [64:0] t_mre;
                logic [64:0] t_mim;
                logic [64:0] t_dre;
                logic [64:0] t_dim;
                logic [64:0] a_mre;
                logic [64:0] a_mim;
                logic [64:0] a_dre;
                logic [64:0] a_dim;
                always_comb
                begin
                    nx     = st_reg[g-1];
                    t_mre  = {nx.p_rr[63], nx.p_rr} - {nx.p_ii[63], nx.p_ii};
                    t_mim  = {nx.p_ri[63], nx.p_ri} + {nx.p_ir[63], nx.p_ir};
                    t_dre  = {nx.p_rr[63], nx.p_rr} + {nx.p_ii[63], nx.p_ii};
                    t_dim  = {nx.p_ir[63], nx.p_ir} - {nx.p_ri[63], nx.p_ri};
                    a_mre  = t_mre[64] ? (65'd0 - t_mre) : t_mre;
                    a_mim  = t_mim[64] ? (65'd0 - t_mim) : t_mim;
                    a_dre  = t_dre[64] ? (65'd0 - t_dre) : t_dre;
                    a_dim  = t_dim[64] ? (65'd0 - t_dim) : t_dim;
                    nx.mre_neg = t_mre[64];
                    nx.mim_neg = t_mim[64];
                    nx.dre_neg = t_dre[64];
                    nx.dim_neg = t_dim[64];
                    nx.mre_mag = a_mre[63:0];
                    nx.mim_mag = a_mim[63:0];
                    nx.dre_num = a_dre[63:0];
                    nx.dim_num = a_dim[63:0];
                    nx.den     = nx.sq_br + nx.sq_bi;
                    nx.msq     = nx.sq_ar + nx.sq_ai;
                end
            end
            else if (g == S_I)
            begin : g_init
                logic signed [63:0] xs;
                logic signed [63:0] ys;
                always_comb
                begin
                    nx         = st_reg[g-1];
                    // Quotient bits above 32 mean the result saturates anyway.
                    nx.dre_rem = nx.dre_num >> (33 - F);
                    nx.dim_rem = nx.dim_num >> (33 - F);
                    nx.dre_ovf = (nx.dre_rem >= nx.den);
                    nx.dim_ovf = (nx.dim_rem >= nx.den);
                    nx.dre_q   = '0;
                    nx.dim_q   = '0;
                    nx.s1_v    = nx.msq;
                    nx.s1_r    = '0;
                    xs         = 64'(nx.ar) <<< 29;
                    ys         = 64'(nx.ai) <<< 29;
                    nx.vbase   = nx.ar[31];
                    nx.vx      = nx.ar[31] ? -xs : xs;
                    nx.vy      = nx.ar[31] ? -ys : ys;
                    nx.vz      = '0;
                    nx.red_neg = nx.ai[31];
                    nx.red     = nx.ai[31] ? (64'd0 - 64'(nx.ai)) : 64'(nx.ai);
                end
            end
            else if (g >= S_A0 && g < S_M1)
            begin : g_seca
                localparam int          S    = g - S_A0;
                localparam int          J    = 32 - S;
                localparam bit          USEB = (S < cau_pkg::DIV_STEPS) && (J >= F);
                localparam int          BP   = USEB ? (J - F) : 0;
                localparam int          QB   = (S < cau_pkg::DIV_STEPS) ? J : 0;
                localparam int          SHB  = (S < cau_pkg::SQRT_STEPS) ? (62 - 2 * S) : 0;
                localparam logic [63:0] BSQ  = 64'd1 << SHB;
                localparam logic [63:0] ATN  = cau_pkg::atan_q60(S);
                logic [64:0]        tre;
                logic [64:0]        tim;
                logic [63:0]        rb;
                logic signed [63:0] dx;
                logic signed [63:0] dy;
                logic [63:0]        r2;
                always_comb
                begin
                    nx  = st_reg[g-1];
                    tre = {nx.dre_rem, USEB ? nx.dre_num[BP] : 1'b0};
                    tim = {nx.dim_rem, USEB ? nx.dim_num[BP] : 1'b0};
                    rb  = nx.s1_r + BSQ;
                    dx  = nx.vy >>> S;
                    dy  = nx.vx >>> S;
                    r2  = nx.red << 1;
                    if (S < cau_pkg::DIV_STEPS)
                    begin
                        if (tre >= {1'b0, nx.den})
                        begin
                            tre          = tre - {1'b0, nx.den};
                            nx.dre_q[QB] = 1'b1;
                        end
                        if (tim >= {1'b0, nx.den})
                        begin
                            tim          = tim - {1'b0, nx.den};
                            nx.dim_q[QB] = 1'b1;
                        end
                        nx.dre_rem = tre[63:0];
                        nx.dim_rem = tim[63:0];
                    end
                    if (S < cau_pkg::SQRT_STEPS)
                    begin
                        if (nx.s1_v >= rb)
                        begin
                            nx.s1_v = nx.s1_v - rb;
                            nx.s1_r = (nx.s1_r >> 1) + BSQ;
                        end
                        else
                        begin
                            nx.s1_r = nx.s1_r >> 1;
                        end
                    end
                    if (S < cau_pkg::NSTEPS)
                    begin
                        if (!nx.vy[63])
                        begin
                            nx.vx = nx.vx + dx;
                            nx.vy = nx.vy - dy;
                            nx.vz = nx.vz + $signed(ATN);
                        end
                        else
                        begin
                            nx.vx = nx.vx - dx;
                            nx.vy = nx.vy + dy;
                            nx.vz = nx.vz - $signed(ATN);
                        end
                    end
                    if (S < cau_pkg::RED_STEPS)
                    begin
                        nx.red = (r2 >= cau_pkg::TWO_PI_Q60) ? (r2 - cau_pkg::TWO_PI_Q60) : r2;
                    end
                end
            end
            else if (g == S_M1)
            begin : g_mid1
                logic signed [63:0] asum;
                logic [32:0]        sv_mre;
                logic [32:0]        sv_mim;
                logic [32:0]        sv_dre;
                logic [32:0]        sv_dim;
                always_comb
                begin
                    nx   = st_reg[g-1];
                    asum = $signed(nx.vbase ? cau_pkg::PI_Q60 : 64'd0) + nx.vz;
                    if (nx.aiz)
                    begin
                        nx.ang = nx.ar[31] ? cau_pkg::PI_Q60 : 64'd0;
                    end
                    else if (nx.arz)
                    begin
                        nx.ang = nx.ai[31] ? cau_pkg::THREE_HALF_PI : cau_pkg::HALF_PI_Q60;
                    end
                    else if (asum[63])
                    begin
                        nx.ang = asum + cau_pkg::TWO_PI_Q60;
                    end
                    else
                    begin
                        nx.ang = asum;
                    end
                    nx.mag1    = nx.s1_r + ((nx.s1_v > nx.s1_r) ? 64'd1 : 64'd0);
                    nx.mag_sat = (nx.mag1 > 64'h7FFFFFFF);
                    sv_mre     = sat_sm(nx.mre_neg, (nx.mre_mag + RND_F) >> F);
                    sv_mim     = sat_sm(nx.mim_neg, (nx.mim_mag + RND_F) >> F);
                    nx.mul_re  = sv_mre[31:0];
                    nx.mul_im  = sv_mim[31:0];
                    nx.mul_sat = sv_mre[32] | sv_mim[32];
                    sv_dre     = nx.dre_ovf ? {1'b1, (nx.dre_neg ? 32'h80000000 : 32'h7FFFFFFF)}
                                            : sat_sm(nx.dre_neg, {31'd0, nx.dre_q});
                    sv_dim     = nx.dim_ovf ? {1'b1, (nx.dim_neg ? 32'h80000000 : 32'h7FFFFFFF)}
                                            : sat_sm(nx.dim_neg, {31'd0, nx.dim_q});
                    nx.div_re  = sv_dre[31:0];
                    nx.div_im  = sv_dim[31:0];
                    nx.div_sat = sv_dre[32] | sv_dim[32];
                    if (nx.red_neg && (nx.red != 64'd0))
                    begin
                        nx.red = cau_pkg::TWO_PI_Q60 - nx.red;
                    end
                end
            end
            else if (g == S_M2)
            begin : g_mid2
                logic [63:0]        afw;
                logic signed [63:0] u;
                always_comb
                begin
                    nx  = st_reg[g-1];
                    afw = (nx.ang + RND_ANG) >> (60 - F);
                    if (afw >= TPF)
                    begin
                        afw = afw - TPF;
                    end
                    nx.af = afw[31:0];
                    u     = (nx.act == cau_pkg::ACT_SQRT) ? $signed(nx.ang >> 1) : $signed(nx.red);
                    nx.rflip = 1'b0;
                    if (u > $signed(cau_pkg::HALF_PI_Q60) && u < $signed(cau_pkg::THREE_HALF_PI))
                    begin
                        nx.rz    = u - $signed(cau_pkg::PI_Q60);
                        nx.rflip = 1'b1;
                    end
                    else if (u >= $signed(cau_pkg::THREE_HALF_PI))
                    begin
                        nx.rz = u - $signed(cau_pkg::TWO_PI_Q60);
                    end
                    else
                    begin
                        nx.rz = u;
                    end
                    nx.rx   = $signed(cau_pkg::INV_GAIN_Q32 << 28);
                    nx.ry   = '0;
                    nx.s2_v = nx.mag1 << F;
                    nx.s2_r = '0;
                end
            end
            else if (g >= S_B0 && g < S_M3)
            begin : g_secb
                localparam int          S   = g - S_B0;
                localparam int          SHB = (S < cau_pkg::SQRT_STEPS) ? (62 - 2 * S) : 0;
                localparam logic [63:0] BSQ = 64'd1 << SHB;
                localparam logic [63:0] ATN = cau_pkg::atan_q60(S);
                logic [63:0]        rb;
                logic signed [63:0] dx;
                logic signed [63:0] dy;
                always_comb
                begin
                    nx = st_reg[g-1];
                    rb = nx.s2_r + BSQ;
                    dx = nx.ry >>> S;
                    dy = nx.rx >>> S;
                    if (S < cau_pkg::NSTEPS)
                    begin
                        if (!nx.rz[63])
                        begin
                            nx.rx = nx.rx - dx;
                            nx.ry = nx.ry + dy;
                            nx.rz = nx.rz - $signed(ATN);
                        end
                        else
                        begin
                            nx.rx = nx.rx + dx;
                            nx.ry = nx.ry - dy;
                            nx.rz = nx.rz + $signed(ATN);
                        end
                    end
                    if (S < cau_pkg::SQRT_STEPS)
                    begin
                        if (nx.s2_v >= rb)
                        begin
                            nx.s2_v = nx.s2_v - rb;
                            nx.s2_r = (nx.s2_r >> 1) + BSQ;
                        end
                        else
                        begin
                            nx.s2_r = nx.s2_r >> 1;
                        end
                    end
                end
            end
            else if (g == S_M3)
            begin : g_mid3
                logic signed [63:0] xf;
                logic signed [63:0] yf;
                logic signed [63:0] xr;
                logic signed [63:0] yr;
                logic [63:0]        mag2;
                always_comb
                begin
                    nx      = st_reg[g-1];
                    xf      = nx.rflip ? -nx.rx : nx.rx;
                    yf      = nx.rflip ? -nx.ry : nx.ry;
                    xr      = (xf + 64'sd536870912) >>> 30;
                    yr      = (yf + 64'sd536870912) >>> 30;
                    nx.cs_c = xr[33:0];
                    nx.cs_s = yr[33:0];
                    mag2    = nx.s2_r + ((nx.s2_v > nx.s2_r) ? 64'd1 : 64'd0);
                    nx.rad  = (nx.act == cau_pkg::ACT_SQRT) ? $signed(mag2[31:0]) : nx.ar;
                end
            end
            else
            begin : g_mul
                always_comb
                begin
                    nx    = st_reg[g-1];
                    nx.pc = nx.rad * nx.cs_c;
                    nx.ps = nx.rad * nx.cs_s;
                end
            end
            assign st_next[g] = nx;
        end
    endgenerate

    // Result selection from the last pipeline stage.
    logic [65:0] am_c;
    logic [65:0] am_s;
    logic [65:0] rm_c;
    logic [65:0] rm_s;
    logic [32:0] sc_c;
    logic [32:0] sc_s;
    logic [32:0] cl_re;
    logic [32:0] cl_im;
    pipe_t       lst;

    always_comb
    begin
        lst  = st_reg[NST-1];
        am_c = lst.pc[65] ? (66'd0 - lst.pc) : lst.pc;
        am_s = lst.ps[65] ? (66'd0 - lst.ps) : lst.ps;
        rm_c = (am_c + 66'd536870912) >> 30;
        rm_s = (am_s + 66'd536870912) >> 30;
        sc_c = sat_sm(lst.pc[65], rm_c[63:0]);
        sc_s = sat_sm(lst.ps[65], rm_s[63:0]);
        cl_re = '0;
        cl_im = '0;
        fin_data = '0;
        fin_user = '0;
        unique case (lst.act)
            cau_pkg::ACT_ADD:
            begin
                cl_re    = clamp33(33'(lst.ar) + 33'(lst.br));
                cl_im    = clamp33(33'(lst.ai) + 33'(lst.bi));
                fin_data = {cl_im[31:0], cl_re[31:0]};
                fin_user = {cl_re[32] | cl_im[32], 2'b00};
            end
            cau_pkg::ACT_SUB:
            begin
                cl_re    = clamp33(33'(lst.ar) - 33'(lst.br));
                cl_im    = clamp33(33'(lst.ai) - 33'(lst.bi));
                fin_data = {cl_im[31:0], cl_re[31:0]};
                fin_user = {cl_re[32] | cl_im[32], 2'b00};
            end
            cau_pkg::ACT_MUL:
            begin
                fin_data = {lst.mul_im, lst.mul_re};
                fin_user = {lst.mul_sat, 2'b00};
            end
            cau_pkg::ACT_DIV:
            begin
                if (lst.bz)
                begin
                    fin_data = {(lst.ai[31] ? 32'h80000000 : 32'h7FFFFFFF),
                                (lst.ar[31] ? 32'h80000000 : 32'h7FFFFFFF)};
                    fin_user = 3'b110;
                end
                else
                begin
                    fin_data = {lst.div_im, lst.div_re};
                    fin_user = {lst.div_sat, 2'b00};
                end
            end
            cau_pkg::ACT_CONJ:
            begin
                cl_im    = clamp33(33'd0 - 33'(lst.ai));
                fin_data = {cl_im[31:0], lst.ar};
                fin_user = {cl_im[32], 2'b00};
            end
            cau_pkg::ACT_POL:
            begin
                fin_data = {lst.af, (lst.mag_sat ? 32'h7FFFFFFF : lst.mag1[31:0])};
                fin_user = {lst.mag_sat, 2'b00};
            end
            cau_pkg::ACT_SQRT, cau_pkg::ACT_FPOL:
            begin
                fin_data = {sc_s[31:0], sc_c[31:0]};
                fin_user = {sc_c[32] | sc_s[32], 2'b00};
            end
            cau_pkg::ACT_CMP:
            begin
                fin_user = {2'b00, lst.eq};
            end
            default:
            begin
                fin_data = '0;
                fin_user = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NST-2:0], in_valid};
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NST; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            out_data_reg <= fin_data;
            out_user_reg <= fin_user;
        end
    end

endmodule

[rtl/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: front end, queue and execution pipeline.
//
//  channel | direction | handshake           | payload
//  input   | slave     | s_tvalid / s_tready | s_tdata: a_re a_im b_re b_im; s_tuser: action
//  result  | master    | m_tvalid / m_tready | m_tdata: res_re res_im; m_tuser: flags
//
// One operation enters per cycle and one result leaves per cycle while m_tready does not stall
// the pipeline; every operation takes the same path: the front register, one queue slot,
// SEC1_LEN + SEC2_LEN + 7 pipeline stages (83 at the default constants) and the output register.
// The long sections are the bit-per-stage dividers and reduction, and the CORDIC and root stages.
// Reset is asynchronous and active low; it empties the queue and the pipeline at once.
// A stall on m_tready holds the whole pipeline; the queue then fills and s_tready drops.
module complex_arithmetic_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [3:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_re, res_im
    output logic [2:0]   m_tuser    // equal, div_by_zero, saturated
);

    logic           fq_valid;
    logic           fq_ready;
    cau_pkg::item_t fq_item;
    logic           qb_valid;
    logic           qb_ready;
    cau_pkg::item_t qb_item;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    cau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    cau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_item  (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[2])
        else $error("division by zero without saturation flag");

    a_dz_val: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |->
        ((m_tdata[31:0] == 32'h7FFFFFFF || m_tdata[31:0] == 32'h80000000) &&
         (m_tdata[63:32] == 32'h7FFFFFFF || m_tdata[63:32] == 32'h80000000)))
        else $error("division by zero result is not a saturated value");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0 && m_tuser[2:1] == 2'b00))
        else $error("compare result carries arithmetic data");
`endif

endmodule
